[rtl/prpbs_pkg.sv]
// Shared types and constants of the pump run and pulse burst sequencer.
package prpbs_pkg;

	// Configuration register indexes.
	localparam int unsigned CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] CFG_DRIVE_ACTIVE_HIGH = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_RUN_TIME_MS       = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_STRIKE_REPEATS    = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_STRIKE_PHASE_MS   = 2'd3;
	localparam int unsigned CFG_DATA_W = 32;

	// Reset values of the configuration registers.
	localparam logic        RST_DRIVE_ACTIVE_HIGH = 1'b1;
	localparam logic [31:0] RST_RUN_TIME_MS       = 32'd300000;
	localparam logic [7:0]  RST_STRIKE_REPEATS    = 8'd9;
	localparam logic [15:0] RST_STRIKE_PHASE_MS   = 16'd125;

	// One loop pass as it arrives.
	typedef struct packed {
		logic [31:0] now_ms;
		logic        request_on;
		logic        request_burst;
		logic        request_off;
	} in_item_t;

	// Result of one loop pass.
	typedef struct packed {
		logic drive_level;
		logic pump_on;
		logic pump_off;
		logic on_event;
		logic off_event;
		logic burst_start_event;
		logic burst_end_event;
	} out_item_t;

	// Configuration register set.
	typedef struct packed {
		logic        drive_active_high;
		logic [31:0] run_time_ms;
		logic [7:0]  strike_repeats;
		logic [15:0] strike_phase_ms;
	} cfg_t;

	// Sticky demands, status flags and pin level.
	typedef struct packed {
		logic pending_on;
		logic pending_burst;
		logic pending_off;
		logic status_on;
		logic status_off;
		logic output_level;
	} seq_flags_t;

	// Sequencer steps, one-hot.
	typedef enum logic [12:0] {
		ST_INIT           = 13'b0_0000_0000_0001,
		ST_WAIT_DEMAND    = 13'b0_0000_0000_0010,
		ST_SWITCH_ON      = 13'b0_0000_0000_0100,
		ST_RUNNING        = 13'b0_0000_0000_1000,
		ST_SWITCH_OFF     = 13'b0_0000_0001_0000,
		ST_BURST_INIT     = 13'b0_0000_0010_0000,
		ST_PULSE_ON       = 13'b0_0000_0100_0000,
		ST_PULSE_ON_WAIT  = 13'b0_0000_1000_0000,
		ST_PULSE_OFF      = 13'b0_0001_0000_0000,
		ST_PULSE_OFF_WAIT = 13'b0_0010_0000_0000,
		ST_PULSE_CHECK    = 13'b0_0100_0000_0000,
		ST_BURST_END      = 13'b0_1000_0000_0000,
		ST_DONE           = 13'b1_0000_0000_0000
	} step_t;

endpackage

[rtl/prpbs_step.sv]
// Next-state and result logic for one pass of the pump sequencer.
module prpbs_step import prpbs_pkg::*; #(
	parameter int unsigned TIME_WIDTH = 32
) (
	input  in_item_t              item,
	input  cfg_t                  cfg,
	input  step_t                 step_cur,
	input  seq_flags_t            flags_cur,
	input  logic [TIME_WIDTH-1:0] phase_cur,
	input  logic [7:0]            count_cur,
	output step_t                 step_nxt,
	output seq_flags_t            flags_nxt,
	output logic [TIME_WIDTH-1:0] phase_nxt,
	output logic [7:0]            count_nxt,
	output out_item_t             result
);

	localparam int unsigned CMP_W = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

	logic [CMP_W-1:0]      now_ext;
	logic [TIME_WIDTH-1:0] now_t;
	logic [TIME_WIDTH-1:0] elapsed;
	logic [CMP_W-1:0]      elapsed_ext;
	logic                  run_done;
	logic                  phase_done;
	logic                  ev_on;
	logic                  ev_off;
	logic                  ev_bs;
	logic                  ev_be;
	seq_flags_t            fl;

	// Time is taken modulo the timer width; elapsed time wraps the same way.
	assign now_ext     = CMP_W'(item.now_ms);
	assign now_t       = now_ext[TIME_WIDTH-1:0];
	assign elapsed     = now_t - phase_cur;
	assign elapsed_ext = CMP_W'(elapsed);
	assign run_done    = elapsed_ext >= CMP_W'(cfg.run_time_ms);
	assign phase_done  = elapsed_ext >= CMP_W'(cfg.strike_phase_ms);

	// Latch the requests of this pass, then advance the sequencer by one step.
	always_comb begin
		fl               = flags_cur;
		fl.pending_on    = flags_cur.pending_on | item.request_on;
		fl.pending_burst = flags_cur.pending_burst | item.request_burst;
		fl.pending_off   = flags_cur.pending_off | item.request_off;
		step_nxt         = step_cur;
		phase_nxt        = phase_cur;
		count_nxt        = count_cur;
		ev_on            = 1'b0;
		ev_off           = 1'b0;
		ev_bs            = 1'b0;
		ev_be            = 1'b0;
		unique case (step_cur)
			ST_INIT: begin
				fl.pending_on    = 1'b0;
				fl.pending_burst = 1'b0;
				fl.pending_off   = 1'b0;
				step_nxt         = ST_WAIT_DEMAND;
			end
			ST_WAIT_DEMAND: begin
				if (fl.pending_on) begin
					fl.pending_on = 1'b0;
					step_nxt      = ST_SWITCH_ON;
				end else if (fl.pending_burst) begin
					fl.pending_burst = 1'b0;
					step_nxt         = ST_BURST_INIT;
				end
			end
			ST_SWITCH_ON: begin
				fl.output_level = cfg.drive_active_high;
				fl.status_on    = 1'b1;
				fl.status_off   = 1'b0;
				fl.pending_off  = 1'b0;
				ev_on           = 1'b1;
				phase_nxt       = now_t;
				step_nxt        = ST_RUNNING;
			end
			ST_RUNNING: begin
				// An off demand is consumed even when the run time is also up.
				if (run_done || fl.pending_off) begin
					step_nxt = ST_SWITCH_OFF;
				end
				fl.pending_off = 1'b0;
			end
			ST_SWITCH_OFF: begin
				fl.output_level = ~cfg.drive_active_high;
				fl.status_on    = 1'b0;
				fl.status_off   = 1'b1;
				ev_off          = 1'b1;
				step_nxt        = ST_DONE;
			end
			ST_BURST_INIT: begin
				count_nxt      = '0;
				fl.status_on   = 1'b1;
				fl.status_off  = 1'b0;
				fl.pending_off = 1'b0;
				ev_bs          = 1'b1;
				step_nxt       = ST_PULSE_ON;
			end
			ST_PULSE_ON: begin
				fl.output_level = cfg.drive_active_high;
				phase_nxt       = now_t;
				step_nxt        = ST_PULSE_ON_WAIT;
			end
			ST_PULSE_ON_WAIT: begin
				if (phase_done) begin
					step_nxt = ST_PULSE_OFF;
				end
			end
			ST_PULSE_OFF: begin
				fl.output_level = ~cfg.drive_active_high;
				phase_nxt       = now_t;
				step_nxt        = ST_PULSE_OFF_WAIT;
			end
			ST_PULSE_OFF_WAIT: begin
				if (phase_done) begin
					step_nxt = ST_PULSE_CHECK;
				end
			end
			ST_PULSE_CHECK: begin
				if (fl.pending_off) begin
					fl.pending_off = 1'b0;
					step_nxt       = ST_BURST_END;
				end else if (count_cur < cfg.strike_repeats) begin
					count_nxt = count_cur + 8'd1;
					step_nxt  = ST_PULSE_ON;
				end else begin
					step_nxt = ST_BURST_END;
				end
			end
			ST_BURST_END: begin
				fl.status_on  = 1'b0;
				fl.status_off = 1'b1;
				ev_be         = 1'b1;
				step_nxt      = ST_DONE;
			end
			default: begin
				// The done step and any stray code return to init.
				step_nxt = ST_INIT;
			end
		endcase
		flags_nxt = fl;
	end

	// Result of the pass reflects the updated flags.
	always_comb begin
		result.drive_level       = fl.output_level;
		result.pump_on           = fl.status_on;
		result.pump_off          = fl.status_off;
		result.on_event          = ev_on;
		result.off_event         = ev_off;
		result.burst_start_event = ev_bs;
		result.burst_end_event   = ev_be;
	end

endmodule

[rtl/pump_run_and_pulse_burst_sequencer.sv]
// Top level of the pump run and pulse burst sequencer.
//
//  Channel   Handshake             Payload            Moves
//  item      item_valid/stall      in_item_t item     one control loop pass in
//  result    result_valid/stall    out_item_t result  one pass result out
//  cfg       cfg_valid/ready       cfg_index/data     one register write
//
// Each accepted item is held in the input register; the step logic then
// writes its result into the output register, and one item is taken every
// cycle while results are drained.
// The sequencer state advances in the same cycle as the output register loads.
// A stalled result holds the input register, which then stalls the item side.
// Reset leaves the sequencer at its init step with the pump switched off.
module pump_run_and_pulse_burst_sequencer import prpbs_pkg::*; #(
	parameter int unsigned TIME_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_stall,
	input  in_item_t               item,
	output logic                   result_valid,
	input  logic                   result_stall,
	output out_item_t              result,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t                  cfg_q;
	logic                  valid_s1;
	in_item_t              item_s1;
	logic                  advance;
	step_t                 step_q;
	step_t                 step_nxt;
	seq_flags_t            flags_q;
	seq_flags_t            flags_nxt;
	logic [TIME_WIDTH-1:0] phase_q;
	logic [TIME_WIDTH-1:0] phase_nxt;
	logic [7:0]            count_q;
	logic [7:0]            count_nxt;
	out_item_t             result_nxt;
	logic                  result_valid_q;
	out_item_t             result_q;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.drive_active_high <= RST_DRIVE_ACTIVE_HIGH;
			cfg_q.run_time_ms       <= RST_RUN_TIME_MS;
			cfg_q.strike_repeats    <= RST_STRIKE_REPEATS;
			cfg_q.strike_phase_ms   <= RST_STRIKE_PHASE_MS;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_DRIVE_ACTIVE_HIGH: cfg_q.drive_active_high <= cfg_data[0];
				CFG_RUN_TIME_MS:       cfg_q.run_time_ms       <= cfg_data;
				CFG_STRIKE_REPEATS:    cfg_q.strike_repeats    <= cfg_data[7:0];
				CFG_STRIKE_PHASE_MS:   cfg_q.strike_phase_ms   <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// The input register empties whenever the output register can take a result.
	assign advance    = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
	end

	prpbs_step #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_step (
		.item      (item_s1),
		.cfg       (cfg_q),
		.step_cur  (step_q),
		.flags_cur (flags_q),
		.phase_cur (phase_q),
		.count_cur (count_q),
		.step_nxt  (step_nxt),
		.flags_nxt (flags_nxt),
		.phase_nxt (phase_nxt),
		.count_nxt (count_nxt),
		.result    (result_nxt)
	);

	// Sequencer state moves on with each transfer into the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q               <= ST_INIT;
			flags_q.pending_on    <= 1'b0;
			flags_q.pending_burst <= 1'b0;
			flags_q.pending_off   <= 1'b0;
			flags_q.status_on     <= 1'b0;
			flags_q.status_off    <= 1'b1;
			flags_q.output_level  <= 1'b0;
			phase_q              <= '0;
			count_q              <= '0;
		end else if (advance) begin
			step_q  <= step_nxt;
			flags_q <= flags_nxt;
			phase_q <= phase_nxt;
			count_q <= count_nxt;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (!result_valid_q || !result_stall) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_nxt;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

[rtl/prpbs_checker.sv]
// Port-level checks on the results of the pump sequencer, with their binding.
module prpbs_checker import prpbs_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      result_valid,
	input logic      result_stall,
	input out_item_t result
);

	// The two status flags always disagree.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.pump_on != result.pump_off))
	else $error("pump_on and pump_off agree");

	// A pass raises at most one event.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $onehot0({result.on_event, result.off_event,
			result.burst_start_event, result.burst_end_event}))
	else $error("more than one event in a pass");

	// Switching on a timed run or starting a burst reports the pump as on.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result.on_event || result.burst_start_event))
		|-> result.pump_on)
	else $error("start event without pump on");

	// An accepted on event cannot be followed at once by another transfer
	// carrying an off event, since at least one step lies between them.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_stall && result.on_event) |=>
		!(result_valid && result.off_event))
	else $error("run switched off straight after switching on");

endmodule

bind pump_run_and_pulse_burst_sequencer prpbs_checker u_prpbs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

[verif/pump_run_and_pulse_burst_sequencer_tb.sv]
// Self-checking testbench of the pump run and pulse burst sequencer.
module pump_run_and_pulse_burst_sequencer_tb;
	import prpbs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROWS = 25;
	localparam int PHASES = 8;
	localparam int PASSES_PER_PHASE = 220;
	localparam int DRAIN_CYCLES = 4;
	localparam int GAP_PCT [4] = '{0, 60, 0, 20};
	localparam int STALL_PCT [4] = '{0, 0, 60, 20};
	localparam logic [CFG_INDEX_W-1:0] REG_ORDER [4] = '{
		CFG_DRIVE_ACTIVE_HIGH, CFG_RUN_TIME_MS, CFG_STRIKE_REPEATS, CFG_STRIKE_PHASE_MS
	};

	// One row of the directed script; reprogram drains the block and loads the
	// inverted polarity with zero run time, zero repeats and zero phase first.
	typedef struct {
		bit        reprogram;
		in_item_t  pass;
		bit        typed;
		out_item_t typed_result;
	} script_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   item_valid = 1'b0;
	logic                   item_stall;
	in_item_t               item = '0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	out_item_t              result;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	// Shadow of the sequencer: registers, step, timer origin, counter, flags.
	cfg_t        shadow_cfg = {RST_DRIVE_ACTIVE_HIGH, RST_RUN_TIME_MS,
		RST_STRIKE_REPEATS, RST_STRIKE_PHASE_MS};
	step_t       p_step = ST_INIT;
	logic [31:0] p_start = '0;
	logic [7:0]  p_count = '0;
	seq_flags_t  seq = '{pending_on: 1'b0, pending_burst: 1'b0, pending_off: 1'b0,
		status_on: 1'b0, status_off: 1'b1, output_level: 1'b0};

	out_item_t   awaited_results [$];
	out_item_t   head_result;
	logic [31:0] clock_ms = '0;
	int          gap_pct = 0;
	int          stall_pct = 0;
	int unsigned mismatches = 0;
	int unsigned passes_sent = 0;
	int unsigned results_checked = 0;
	int unsigned runs_seen = 0;
	int unsigned bursts_seen = 0;
	int unsigned settings_used = 1;
	string       field_names [7] = '{"drive_level", "pump_on", "pump_off", "on_event",
		"off_event", "burst_start_event", "burst_end_event"};

	// Field order of typed results: level, on, off, on_ev, off_ev, burst start, burst end.
	script_row_t script [ROWS] = '{
		'{1'b0, '{32'd0, 1'b1, 1'b1, 1'b1}, 1'b1, 7'b0010000},
		'{1'b0, '{32'd1, 1'b1, 1'b0, 1'b0}, 1'b0, 7'b0},
		'{1'b0, '{32'd3, 1'b0, 1'b0, 1'b1}, 1'b1, 7'b1101000},
		'{1'b0, '{32'd300003, 1'b0, 1'b0, 1'b1}, 1'b0, 7'b0},
		'{1'b0, '{32'd300004, 1'b0, 1'b0, 1'b0}, 1'b1, 7'b0010100},
		'{1'b0, '{32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0}, 1'b0, 7'b0},
		'{1'b0, '{32'hFFFF_FFF0, 1'b0, 1'b0, 1'b0}, 1'b0, 7'b0},
		'{1'b0, '{32'hFFFF_FFF0, 1'b0, 1'b1, 1'b0}, 1'b0, 7'b0},
		'{1'b0, '{32'hFFFF_FFF8, 1'b0, 1'b0, 1'b0}, 1'b1, 7'b0100010},
		'{1'b0, '{32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0}, 1'b0, 7'b0},
		'{1'b0, '{32'd124, 1'b0, 1'b0, 1'b0}, 1'b0, 7'b0},
		'{1'b0, '{32'd200, 1'b0, 1'b0, 1'b0}, 1'b0, 7'b0},
		'{1'b0, '{32'd324, 1'b0, 1'b0, 1'b0}, 1'b0, 7'b0},
		'{1'b0, '{32'd325, 1'b0, 1'b0, 1'b1}, 1'b0, 7'b0},
		'{1'b0, '{32'd326, 1'b0, 1'b0, 1'b0}, 1'b0, 7'b0},
		'{1'b0, '{32'd327, 1'b0, 1'b0, 1'b0}, 1'b1, 7'b0010001},
		'{1'b0, '{32'd328, 1'b0, 1'b0, 1'b0}, 1'b0, 7'b0},
		'{1'b0, '{32'd329, 1'b0, 1'b0, 1'b0}, 1'b0, 7'b0},
		'{1'b1, '{32'd330, 1'b0, 1'b1, 1'b0}, 1'b0, 7'b0},
		'{1'b0, '{32'd330, 1'b0, 1'b0, 1'b0}, 1'b0, 7'b0},
		'{1'b0, '{32'd330, 1'b0, 1'b0, 1'b0}, 1'b0, 7'b0},
		'{1'b0, '{32'd330, 1'b0, 1'b0, 1'b0}, 1'b0, 7'b0},
		'{1'b0, '{32'd330, 1'b0, 1'b0, 1'b0}, 1'b0, 7'b0},
		'{1'b0, '{32'd330, 1'b0, 1'b0, 1'b0}, 1'b0, 7'b0},
		'{1'b0, '{32'd330, 1'b0, 1'b0, 1'b0}, 1'b0, 7'b0}
	};

	pump_run_and_pulse_burst_sequencer i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// Free-running clock, 20 ns period.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Advances the shadow sequencer by one loop pass and returns its result.
	function automatic out_item_t advance_sequencer(input in_item_t pass);
		out_item_t   r;
		logic [31:0] since;
		r = '0;
		since = pass.now_ms - p_start;
		// Requests are latched before the step runs.
		if (pass.request_on) seq.pending_on = 1'b1;
		if (pass.request_burst) seq.pending_burst = 1'b1;
		if (pass.request_off) seq.pending_off = 1'b1;
		case (p_step)
			ST_INIT: begin
				seq.pending_on = 1'b0;
				seq.pending_burst = 1'b0;
				seq.pending_off = 1'b0;
				p_step = ST_WAIT_DEMAND;
			end
			ST_WAIT_DEMAND: begin
				if (seq.pending_on) begin
					seq.pending_on = 1'b0;
					p_step = ST_SWITCH_ON;
				end else if (seq.pending_burst) begin
					seq.pending_burst = 1'b0;
					p_step = ST_BURST_INIT;
				end
			end
			ST_SWITCH_ON: begin
				seq.output_level = shadow_cfg.drive_active_high;
				seq.status_on = 1'b1;
				seq.status_off = 1'b0;
				seq.pending_off = 1'b0;
				r.on_event = 1'b1;
				p_start = pass.now_ms;
				p_step = ST_RUNNING;
			end
			ST_RUNNING: begin
				// An off demand is consumed even when the run time has also run out.
				if (since >= shadow_cfg.run_time_ms) p_step = ST_SWITCH_OFF;
				if (seq.pending_off) begin
					seq.pending_off = 1'b0;
					p_step = ST_SWITCH_OFF;
				end
			end
			ST_SWITCH_OFF: begin
				seq.output_level = ~shadow_cfg.drive_active_high;
				seq.status_on = 1'b0;
				seq.status_off = 1'b1;
				r.off_event = 1'b1;
				p_step = ST_DONE;
			end
			ST_BURST_INIT: begin
				p_count = '0;
				seq.status_on = 1'b1;
				seq.status_off = 1'b0;
				seq.pending_off = 1'b0;
				r.burst_start_event = 1'b1;
				p_step = ST_PULSE_ON;
			end
			ST_PULSE_ON: begin
				seq.output_level = shadow_cfg.drive_active_high;
				p_start = pass.now_ms;
				p_step = ST_PULSE_ON_WAIT;
			end
			ST_PULSE_ON_WAIT: begin
				if (since >= {16'd0, shadow_cfg.strike_phase_ms}) p_step = ST_PULSE_OFF;
			end
			ST_PULSE_OFF: begin
				seq.output_level = ~shadow_cfg.drive_active_high;
				p_start = pass.now_ms;
				p_step = ST_PULSE_OFF_WAIT;
			end
			ST_PULSE_OFF_WAIT: begin
				if (since >= {16'd0, shadow_cfg.strike_phase_ms}) p_step = ST_PULSE_CHECK;
			end
			ST_PULSE_CHECK: begin
				// An off demand ends the burst at the end of a pulse.
				if (seq.pending_off) begin
					seq.pending_off = 1'b0;
					p_step = ST_BURST_END;
				end else if (p_count < shadow_cfg.strike_repeats) begin
					p_count = p_count + 8'd1;
					p_step = ST_PULSE_ON;
				end else begin
					p_step = ST_BURST_END;
				end
			end
			ST_BURST_END: begin
				seq.status_on = 1'b0;
				seq.status_off = 1'b1;
				r.burst_end_event = 1'b1;
				p_step = ST_DONE;
			end
			default: begin
				p_step = ST_INIT;
			end
		endcase
		r.drive_level = seq.output_level;
		r.pump_on = seq.status_on;
		r.pump_off = seq.status_off;
		return r;
	endfunction

	// Random loop pass: mostly short time steps, some of a phase or run length,
	// now and then a jump anywhere on the wrapping time line.
	function automatic in_item_t random_pass();
		in_item_t    pass;
		int unsigned roll;
		logic [31:0] run_span;
		roll = $urandom_range(99);
		run_span = (shadow_cfg.run_time_ms > 32'd2000) ? 32'd2000 : shadow_cfg.run_time_ms + 32'd2;
		if (roll < 55)
			clock_ms = clock_ms + $urandom_range(3);
		else if (roll < 90)
			clock_ms = clock_ms + $urandom_range({16'd0, shadow_cfg.strike_phase_ms} + 32'd2);
		else if (roll < 97)
			clock_ms = clock_ms + $urandom_range(run_span);
		else
			clock_ms = $urandom();
		pass.now_ms = clock_ms;
		pass.request_on = ($urandom_range(99) < 7);
		pass.request_burst = ($urandom_range(99) < 7);
		pass.request_off = ($urandom_range(99) < 3);
		return pass;
	endfunction

	// Offers one pass after a random gap and records its expected result once
	// the transfer has taken place. Valid stays high for a following pass.
	task automatic send_pass(input in_item_t pass, input bit typed,
			input out_item_t typed_result);
		out_item_t predicted;
		while ($urandom_range(99) < gap_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= pass;
		do @(posedge clk); while (item_stall);
		predicted = advance_sequencer(pass);
		awaited_results.push_back(typed ? typed_result : predicted);
		passes_sent++;
	endtask

	// Withdraws the sender and waits until every awaited result has arrived.
	task automatic settle();
		item_valid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes all four registers back to back and mirrors them in the shadow.
	task automatic program_registers(input logic pol, input logic [31:0] run,
			input logic [7:0] repeats, input logic [15:0] phase);
		logic [CFG_DATA_W-1:0] values [4];
		values[0] = {31'd0, pol};
		values[1] = run;
		values[2] = {24'd0, repeats};
		values[3] = {16'd0, phase};
		for (int k = 0; k < 4; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= REG_ORDER[k];
			cfg_data <= values[k];
			do @(posedge clk); while (!cfg_ready);
			case (REG_ORDER[k])
				CFG_DRIVE_ACTIVE_HIGH: shadow_cfg.drive_active_high = values[k][0];
				CFG_RUN_TIME_MS:       shadow_cfg.run_time_ms = values[k];
				CFG_STRIKE_REPEATS:    shadow_cfg.strike_repeats = values[k][7:0];
				CFG_STRIKE_PHASE_MS:   shadow_cfg.strike_phase_ms = values[k][15:0];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// Receiver back-pressure.
	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	// Each result transfer is compared field by field with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (awaited_results.size() == 0) begin
				$display("%0t: unexpected result %b, expected none", $time, result);
				mismatches++;
			end else begin
				head_result = awaited_results.pop_front();
				for (int b = 6; b >= 0; b--) begin
					if (result[b] !== head_result[b]) begin
						$display("%0t: %s expected %b got %b", $time, field_names[6-b],
							head_result[b], result[b]);
						mismatches++;
					end
				end
				results_checked++;
				if (result.on_event) runs_seen++;
				if (result.burst_start_event) bursts_seen++;
			end
		end
	end

	// Main sequence: reset, directed script, random phases, final report.
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (script[i]) begin
			if (script[i].reprogram) begin
				settle();
				program_registers(1'b0, 32'd0, 8'd0, 16'd0);
			end
			send_pass(script[i].pass, script[i].typed, script[i].typed_result);
		end

		clock_ms = $urandom();
		for (int p = 0; p < PHASES; p++) begin
			settle();
			gap_pct = GAP_PCT[p % 4];
			stall_pct = STALL_PCT[p % 4];
			case (p)
				0: ;
				1: program_registers(1'b1, 32'd0, 8'd255, 16'd1);
				2: program_registers(1'b0, 32'hFFFF_FFFF, 8'd0, 16'd65535);
				3: program_registers(RST_DRIVE_ACTIVE_HIGH, RST_RUN_TIME_MS,
					RST_STRIKE_REPEATS, RST_STRIKE_PHASE_MS);
				default: program_registers(1'($urandom_range(1)), 32'($urandom_range(400)),
					8'($urandom_range(12)), 16'($urandom_range(60, 1)));
			endcase
			for (int n = 0; n < PASSES_PER_PHASE; n++)
				send_pass(random_pass(), 1'b0, '0);
		end
		settle();

		$display("Sent %0d loop passes under %0d register settings and four idling patterns;",
			passes_sent, settings_used);
		$display("checked %0d results covering %0d timed runs and %0d pulse bursts.",
			results_checked, runs_seen, bursts_seen);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Watchdog far beyond the slowest correct run.
	initial begin
		#4_000_000;
		$display("Timed out with %0d results still awaited.", awaited_results.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule
